@@ rtl/core/chx_pkg.sv @@
// ----------------------------------------------------------------------------
// chx_pkg
// Shared types and constants for the C hex array text-to-bytes parser.
// ----------------------------------------------------------------------------
`default_nettype none

package chx_pkg;

    // Input word: one character of source text
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_byte;
        logic [2:0]  status;
        logic        final_res;
        logic [23:0] byte_count;
    } t_out_word;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INCOMPLETE = 3'd1;
    localparam logic [2:0] ST_NO_DECL    = 3'd2;
    localparam logic [2:0] ST_NO_SIZE    = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd4;
    localparam logic [2:0] ST_NO_BRACE   = 3'd5;
    localparam logic [2:0] ST_NO_BYTES   = 3'd6;

    // Register map
    localparam int          APB_ADDR_W   = 3;
    localparam logic [23:0] MAX_BYTES_RST = 24'd200000;

    // Declaration phrase "const unsigned char"
    localparam logic [4:0] PHRASE_LEN   = 5'd19;
    localparam logic [4:0] PHRASE_RETRY = 5'd16;   // matched length up to the second 'c'
    localparam logic [24:0] SIZE_CAP    = 25'h1FFFFFF;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    function automatic logic [7:0] phrase_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "c";
            5'd1:    c = "o";
            5'd2:    c = "n";
            5'd3:    c = "s";
            5'd4:    c = "t";
            5'd5:    c = " ";
            5'd6:    c = "u";
            5'd7:    c = "n";
            5'd8:    c = "s";
            5'd9:    c = "i";
            5'd10:   c = "g";
            5'd11:   c = "n";
            5'd12:   c = "e";
            5'd13:   c = "d";
            5'd14:   c = " ";
            5'd15:   c = "c";
            5'd16:   c = "h";
            5'd17:   c = "a";
            5'd18:   c = "r";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Hex digit value; 16 marks a non-hex character
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= "0" && c <= "9") begin
            v = 5'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            v = 5'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            v = 5'(c - "A" + 8'd10);
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == " ") || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/c_hex_array_text_to_bytes_unit.sv @@
// ----------------------------------------------------------------------------
// c_hex_array_text_to_bytes_unit
// Streaming parser: finds a "const unsigned char" array declaration in C
// text and emits its 0x.. bytes in pair-swapped order plus a final status.
// ----------------------------------------------------------------------------
// Takes one text character per cycle while the result queue has room. A
// character is registered, then parsed combinationally against the parser
// state, and the 0 to 3 result words it causes are written into a four-word
// queue that drives the output port. A character that produces one or no word
// never holds up the stream while the output is drained every cycle; a
// character that produces two or three words (a byte pair, with or without a
// closing status) holds the input until the queue is back to one word, since
// the output port moves one word per cycle. max_bytes sits at byte address 0.
`default_nettype none

module c_hex_array_text_to_bytes_unit #(
    parameter int COUNT_BITS = 24
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // text input
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire chx_pkg::t_in_word       i_in_word,
    // results
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output chx_pkg::t_out_word           o_out_word,
    // register port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [chx_pkg::APB_ADDR_W-1:0] paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import chx_pkg::*;

    localparam logic [32:0] CountMask = (33'd1 << COUNT_BITS) - 33'd1;

    typedef enum logic [5:0] {
        PH_SEARCH   = 6'b000001,
        PH_LBRACKET = 6'b000010,
        PH_SIZE     = 6'b000100,
        PH_BRACE    = 6'b001000,
        PH_DATA     = 6'b010000,
        PH_DONE     = 6'b100000
    } t_phase;

    typedef enum logic [3:0] {
        SS_BLANK = 4'b0001,
        SS_POS   = 4'b0010,
        SS_NEG   = 4'b0100,
        SS_END   = 4'b1000
    } t_size_sub;

    typedef enum logic [3:0] {
        TK_IDLE = 4'b0001,
        TK_ZERO = 4'b0010,
        TK_X    = 4'b0100,
        TK_HIGH = 4'b1000
    } t_tok;

    // config register
    logic [23:0] r_max_bytes;
    logic        cfg_wr;

    // input stage
    logic     r_in_vld;
    t_in_word r_in;
    logic     fire;

    // parser state
    t_phase                r_phase,    n_phase;
    logic [4:0]            r_match,    n_match;
    t_size_sub             r_sub,      n_sub;
    logic [24:0]           r_acc,      n_acc;
    t_tok                  r_tok,      n_tok;
    logic [3:0]            r_high,     n_high;
    logic [7:0]            r_held,     n_held;
    logic                  r_held_vld, n_held_vld;
    logic [COUNT_BITS-1:0] r_count,    n_count;

    // results of this step
    t_out_word       res [4];
    logic [1:0]      push_n;

    // result queue
    t_out_word             r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_fifo_cnt;
    logic                  pop;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[APB_ADDR_W-1];
    assign prdata = paddr[APB_ADDR_W-1] ? 32'd0 : {8'd0, r_max_bytes};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RST;
        end else if (cfg_wr) begin
            r_max_bytes <= pwdata[23:0];
        end
    end

    // ------------------------------------------------------------------
    // Input stage: parse when the queue has room for three words
    // ------------------------------------------------------------------
    assign fire       = r_in_vld && (r_fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 3));
    assign o_in_ready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    // ------------------------------------------------------------------
    // Parser step
    // ------------------------------------------------------------------
    always_comb begin
        logic [7:0]  c;
        logic [4:0]  hv;
        logic [28:0] prod;
        logic [24:0] sz;
        logic        bad;
        logic        got;
        logic        done;
        logic [7:0]  v;
        logic [2:0]  st;
        logic [31:0] cnt32;

        c          = r_in.ch;
        hv         = hex_value(c);
        prod       = {r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + 29'(c - "0");
        sz         = (r_sub == SS_NEG) ? 25'd0 : r_acc;
        bad        = 1'b0;
        got        = 1'b0;
        done       = 1'b0;
        v          = {r_high, hv[3:0]};
        st         = ST_OK;
        cnt32      = 32'd0;

        n_phase    = r_phase;
        n_match    = r_match;
        n_sub      = r_sub;
        n_acc      = r_acc;
        n_tok      = r_tok;
        n_high     = r_high;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_count    = r_count;

        for (int k = 0; k < 4; k++) begin
            res[k] = '0;
        end
        push_n = 2'd0;

        case (r_phase)
            // phrase match with one-step fallback
            PH_SEARCH: begin
                if (c == phrase_char(r_match)) begin
                    if (r_match == PHRASE_LEN - 5'd1) begin
                        n_phase = PH_LBRACKET;
                        n_match = 5'd0;
                    end else begin
                        n_match = r_match + 5'd1;
                    end
                end else if (r_match == PHRASE_RETRY && c == "o") begin
                    n_match = 5'd2;
                end else begin
                    n_match = (c == "c") ? 5'd1 : 5'd0;
                end
            end
            PH_LBRACKET: begin
                if (c == "[") begin
                    n_phase = PH_SIZE;
                    n_sub   = SS_BLANK;
                    n_acc   = 25'd0;
                end
            end
            // atoi-style size, saturating
            PH_SIZE: begin
                if (c == "]") begin
                    n_acc = sz;
                    bad   = (sz == 25'd0) || (sz > {1'b0, r_max_bytes})
                            || ({8'd0, sz} > CountMask);
                    if (bad) begin
                        res[0].status    = ST_BAD_SIZE;
                        res[0].final_res = 1'b1;
                        push_n           = 2'd1;
                        n_phase          = PH_DONE;
                    end else begin
                        n_phase = PH_BRACE;
                    end
                end else begin
                    case (r_sub)
                        SS_BLANK: begin
                            if (is_blank(c)) begin
                                n_sub = SS_BLANK;
                            end else if (c == "+") begin
                                n_sub = SS_POS;
                            end else if (c == "-") begin
                                n_sub = SS_NEG;
                            end else if (!is_digit(c)) begin
                                n_sub = SS_END;
                            end else begin
                                n_sub = SS_POS;
                                n_acc = (prod > {4'd0, SIZE_CAP}) ? SIZE_CAP : prod[24:0];
                            end
                        end
                        SS_POS: begin
                            if (is_digit(c)) begin
                                n_acc = (prod > {4'd0, SIZE_CAP}) ? SIZE_CAP : prod[24:0];
                            end else begin
                                n_sub = SS_END;
                            end
                        end
                        SS_NEG: begin
                            if (!is_digit(c)) begin
                                n_sub = SS_END;
                            end
                        end
                        default: begin
                            n_sub = SS_END;
                        end
                    endcase
                end
            end
            PH_BRACE: begin
                if (c == "{") begin
                    n_phase = PH_DATA;
                    n_tok   = TK_IDLE;
                end
            end
            // 0x token scan
            PH_DATA: begin
                case (r_tok)
                    TK_ZERO: begin
                        if (c == "x" || c == "X") begin
                            n_tok = TK_X;
                        end else begin
                            n_tok = (c == "0") ? TK_ZERO : TK_IDLE;
                        end
                    end
                    TK_X: begin
                        if (!hv[4]) begin
                            n_high = hv[3:0];
                            n_tok  = TK_HIGH;
                        end else begin
                            n_tok = TK_IDLE;
                        end
                    end
                    TK_HIGH: begin
                        if (!hv[4]) begin
                            got   = 1'b1;
                            n_tok = TK_IDLE;
                        end else begin
                            n_tok = (c == "0") ? TK_ZERO : TK_IDLE;
                        end
                    end
                    default: begin
                        n_tok = (c == "0") ? TK_ZERO : TK_IDLE;
                    end
                endcase

                if (got) begin
                    n_count = r_count + 1'b1;
                    done    = (33'(n_count) >= 33'(r_acc));
                    if (r_held_vld) begin
                        // pair swap: newer byte first
                        res[0].data_byte = v;
                        res[0].has_byte  = 1'b1;
                        res[1].data_byte = r_held;
                        res[1].has_byte  = 1'b1;
                        res[1].final_res = done;
                        push_n           = 2'd2;
                        n_held_vld       = 1'b0;
                    end else if (done) begin
                        res[0].data_byte = v;
                        res[0].has_byte  = 1'b1;
                        res[0].final_res = 1'b1;
                        push_n           = 2'd1;
                    end else begin
                        n_held     = v;
                        n_held_vld = 1'b1;
                    end
                    if (done) begin
                        n_phase = PH_DONE;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // end of text: closing status word, then clear
        if (r_in.end_of_text) begin
            if (n_phase != PH_DONE) begin
                if (n_phase == PH_SEARCH) begin
                    st = ST_NO_DECL;
                end else if (n_phase == PH_LBRACKET || n_phase == PH_SIZE) begin
                    st = ST_NO_SIZE;
                end else if (n_phase == PH_BRACE) begin
                    st = ST_NO_BRACE;
                end else begin
                    st = (n_count == '0) ? ST_NO_BYTES : ST_INCOMPLETE;
                end
                res[push_n].status    = st;
                res[push_n].final_res = 1'b1;
                if (n_phase == PH_DATA && n_held_vld) begin
                    res[push_n].data_byte = n_held;
                    res[push_n].has_byte  = 1'b1;
                end
                push_n = push_n + 2'd1;
            end
        end

        // all words of one step carry the same count
        cnt32 = 32'(n_count);
        for (int k = 0; k < 4; k++) begin
            res[k].byte_count = cnt32[23:0];
        end

        if (r_in.end_of_text) begin
            n_phase    = PH_SEARCH;
            n_match    = 5'd0;
            n_sub      = SS_BLANK;
            n_acc      = 25'd0;
            n_tok      = TK_IDLE;
            n_high     = 4'd0;
            n_held     = 8'd0;
            n_held_vld = 1'b0;
            n_count    = '0;
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SEARCH;
            r_match    <= 5'd0;
            r_sub      <= SS_BLANK;
            r_acc      <= 25'd0;
            r_tok      <= TK_IDLE;
            r_high     <= 4'd0;
            r_held     <= 8'd0;
            r_held_vld <= 1'b0;
            r_count    <= '0;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_match    <= n_match;
            r_sub      <= n_sub;
            r_acc      <= n_acc;
            r_tok      <= n_tok;
            r_high     <= n_high;
            r_held     <= n_held;
            r_held_vld <= n_held_vld;
            r_count    <= n_count;
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_fifo_cnt != '0);
    assign o_out_word  = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        logic [FIFO_PTR_W-1:0] ofs;
        for (int j = 0; j < FIFO_DEPTH; j++) begin
            ofs = FIFO_PTR_W'(j) - r_wr_ptr;
            if (fire && (ofs < push_n)) begin
                r_fifo[j] <= res[ofs];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (fire) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(push_n);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fifo_cnt <= r_fifo_cnt
                          + (fire ? FIFO_CNT_W'(push_n) : '0)
                          - FIFO_CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/chx_checker.sv @@
// ----------------------------------------------------------------------------
// chx_checker
// Port-level checks on the result channel of the hex array parser.
// ----------------------------------------------------------------------------
`default_nettype none

module chx_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input wire chx_pkg::t_out_word o_out_word
);
    import chx_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // queue is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // only the closing word carries a status
    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.final_res |-> o_out_word.status == ST_OK)
        else $error("status on a non-final word");

    // a word without a byte carries zero data
    a_empty_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.has_byte |-> o_out_word.data_byte == 8'd0)
        else $error("data on a word without a byte");

    // no status code beyond the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.status != 3'd7)
        else $error("undefined status code");

endmodule

bind c_hex_array_text_to_bytes_unit chx_checker u_chx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: C hex array text-to-bytes parser testbench
// Streams C-like source text into the parser one character word at a time,
// predicts every result word from a software copy of the parser state and
// compares field by field. Runs several max_bytes limits under four
// flow-control modes on both the text and the result channel.
// ----------------------------------------------------------------------------

module tb;
    import chx_pkg::*;

    typedef enum logic [2:0] {
        PH_SEEK, PH_BRACKET, PH_SIZE, PH_BRACE, PH_DATA, PH_DONE
    } t_phase;
    typedef enum logic [1:0] {SZ_BLANKS, SZ_PLUS, SZ_MINUS, SZ_END} t_size_sub;
    typedef enum logic [1:0] {TK_IDLE, TK_ZERO, TK_X, TK_HIGH} t_token;

    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_BYTES = '0;
    localparam int STALL_LIMIT = 4000;   // cycles with no word moving
    localparam int SEG_CHARS   = 80;     // text characters per limit setting
    localparam int SETTLE      = 8;      // pipeline plus result queue

    // ------------------------------------------------------------------------
    // Byte scoreboard: tracks parser state and the result words still due
    // ------------------------------------------------------------------------
    class array_byte_board;
        t_out_word   words_due[$];
        logic [23:0] limit_bytes;
        string       decl_text = "const unsigned char";
        t_phase      ph;
        logic [4:0]  mpos;
        t_size_sub   ssub;
        logic [24:0] sacc;
        t_token      tok;
        logic [3:0]  hi_nib;
        logic [7:0]  held;
        logic        held_ok;
        logic [23:0] cnt;
        int unsigned errors;
        int unsigned words_checked;
        int unsigned bytes_checked;
        logic [7:0]  status_seen;

        function new();
            limit_bytes   = MAX_BYTES_RST;
            errors        = 0;
            words_checked = 0;
            bytes_checked = 0;
            status_seen   = '0;
            restart();
        endfunction

        function void restart();
            ph      = PH_SEEK;
            mpos    = '0;
            ssub    = SZ_BLANKS;
            sacc    = '0;
            tok     = TK_IDLE;
            hi_nib  = '0;
            held    = '0;
            held_ok = 1'b0;
            cnt     = '0;
        endfunction

        function logic [4:0] nibble_of(logic [7:0] c);
            if (c >= "0" && c <= "9") return 5'(c - 8'h30);
            if (c >= "a" && c <= "f") return 5'(c - 8'h61 + 8'd10);
            if (c >= "A" && c <= "F") return 5'(c - 8'h41 + 8'd10);
            return 5'd16;
        endfunction

        function void due_word(logic [7:0] d, logic hb, logic [2:0] st, logic fin);
            t_out_word w;
            w.data_byte  = d;
            w.has_byte   = hb;
            w.status     = st;
            w.final_res  = fin;
            w.byte_count = cnt;
            words_due.push_back(w);
        endfunction

        // Advance the parser by one accepted text word
        function void note_char(t_in_word w);
            logic [7:0]  c;
            logic [4:0]  nib;
            logic [7:0]  val;
            logic        got;
            logic        done;
            logic        dig;
            logic        take;
            logic [24:0] sz;
            logic [35:0] acc;
            logic [2:0]  st;
            c    = w.ch;
            got  = 1'b0;
            take = 1'b0;
            val  = '0;
            dig  = (c >= "0") && (c <= "9");
            nib  = nibble_of(c);
            case (ph)
                PH_SEEK: begin
                    if (mpos < PHRASE_LEN && c == decl_text[mpos]) begin
                        mpos = mpos + 5'd1;
                        if (mpos == PHRASE_LEN) begin
                            ph   = PH_BRACKET;
                            mpos = '0;
                        end
                    end else if (mpos == PHRASE_RETRY && c == "o") begin
                        // "const unsigned co..." restarts at the 'n'
                        mpos = 5'd2;
                    end else begin
                        mpos = (c == "c") ? 5'd1 : 5'd0;
                    end
                end
                PH_BRACKET: begin
                    if (c == "[") begin
                        ph   = PH_SIZE;
                        ssub = SZ_BLANKS;
                        sacc = '0;
                    end
                end
                PH_SIZE: begin
                    if (c == "]") begin
                        sz   = (ssub == SZ_MINUS) ? 25'd0 : sacc;
                        sacc = sz;
                        if (sz < 25'd1 || sz > {1'b0, limit_bytes}) begin
                            due_word(8'h00, 1'b0, ST_BAD_SIZE, 1'b1);
                            ph = PH_DONE;
                        end else begin
                            ph = PH_BRACE;
                        end
                    end else begin
                        // atoi-style: blanks, one sign, digits, then ignore
                        if (ssub == SZ_BLANKS) begin
                            if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
                                if (c == "+") ssub = SZ_PLUS;
                                else if (c == "-") ssub = SZ_MINUS;
                                else if (!dig) ssub = SZ_END;
                                else begin
                                    ssub = SZ_PLUS;
                                    take = 1'b1;
                                end
                            end
                        end else if (ssub == SZ_PLUS && dig) begin
                            take = 1'b1;
                        end else if (!(ssub == SZ_MINUS && dig)) begin
                            ssub = SZ_END;
                        end
                        if (take) begin
                            acc  = {11'b0, sacc} * 36'd10 + 36'(c - 8'h30);
                            sacc = (acc > 36'(SIZE_CAP)) ? SIZE_CAP : acc[24:0];
                        end
                    end
                end
                PH_BRACE: begin
                    if (c == "{") begin
                        ph  = PH_DATA;
                        tok = TK_IDLE;
                    end
                end
                PH_DATA: begin
                    case (tok)
                        TK_ZERO: begin
                            if (c == "x" || c == "X") tok = TK_X;
                            else tok = (c == "0") ? TK_ZERO : TK_IDLE;
                        end
                        TK_X: begin
                            if (nib < 5'd16) begin
                                hi_nib = nib[3:0];
                                tok    = TK_HIGH;
                            end else begin
                                tok = TK_IDLE;
                            end
                        end
                        TK_HIGH: begin
                            if (nib < 5'd16) begin
                                val = {hi_nib, nib[3:0]};
                                got = 1'b1;
                                tok = TK_IDLE;
                            end else begin
                                // bad low digit: this char may start a token
                                tok = (c == "0") ? TK_ZERO : TK_IDLE;
                            end
                        end
                        default: tok = (c == "0") ? TK_ZERO : TK_IDLE;
                    endcase
                    if (got) begin
                        cnt  = cnt + 24'd1;
                        done = ({1'b0, cnt} >= sacc);
                        // pair swap: second byte leaves ahead of the held one
                        if (held_ok) begin
                            due_word(val, 1'b1, ST_OK, 1'b0);
                            due_word(held, 1'b1, ST_OK, done);
                            held_ok = 1'b0;
                        end else if (done) begin
                            due_word(val, 1'b1, ST_OK, 1'b1);
                        end else begin
                            held    = val;
                            held_ok = 1'b1;
                        end
                        if (done) ph = PH_DONE;
                    end
                end
                default: begin
                end
            endcase

            // End of text: closing status unless already finished
            if (w.end_of_text) begin
                if (ph != PH_DONE) begin
                    if (ph == PH_SEEK) st = ST_NO_DECL;
                    else if (ph == PH_BRACKET || ph == PH_SIZE) st = ST_NO_SIZE;
                    else if (ph == PH_BRACE) st = ST_NO_BRACE;
                    else st = (cnt == '0) ? ST_NO_BYTES : ST_INCOMPLETE;
                    if (ph == PH_DATA && held_ok) due_word(held, 1'b1, st, 1'b1);
                    else due_word(8'h00, 1'b0, st, 1'b1);
                end
                restart();
            end
        endfunction

        function void same_field(string name, logic [23:0] want, logic [23:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result word with the oldest one due
        function void check_word(t_out_word got);
            t_out_word want;
            if (words_due.size() == 0) begin
                $error("result word %h arrived with nothing due", got);
                errors++;
                return;
            end
            want = words_due.pop_front();
            same_field("data_byte", 24'(want.data_byte), 24'(got.data_byte));
            same_field("has_byte", 24'(want.has_byte), 24'(got.has_byte));
            same_field("status", 24'(want.status), 24'(got.status));
            same_field("final_res", 24'(want.final_res), 24'(got.final_res));
            same_field("byte_count", want.byte_count, got.byte_count);
            words_checked++;
            if (want.has_byte) bytes_checked++;
            if (want.final_res) status_seen[want.status] = 1'b1;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_word              i_in_word   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [31:0]           pwdata      = '0;
    wire                   o_in_ready;
    wire                   o_out_valid;
    t_out_word             o_out_word;
    wire  [31:0]           prdata;
    wire                   pready;

    c_hex_array_text_to_bytes_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    array_byte_board board = new();

    logic [7:0]  text_buf[$];
    int          gap_pct     = 0;
    int          stall_pct   = 0;
    int          idle_cycles = 0;
    int unsigned chars_sent  = 0;
    int unsigned texts_sent  = 0;
    int unsigned limits_used = 1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check accepted words, random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_word(o_out_word);
        i_out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles where no word moves on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'(8'h30 + v);
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
    endfunction

    task automatic send_char(t_in_word w);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_char(w);
        chars_sent++;
    endtask

    // Send the buffered text, end-of-text mark on its last character
    task automatic send_text();
        t_in_word w;
        for (int i = 0; i < text_buf.size(); i++) begin
            w.ch          = text_buf[i];
            w.end_of_text = (i == text_buf.size() - 1);
            send_char(w);
        end
        text_buf.delete();
        texts_sent++;
    endtask

    // Wait until every due word is back and the pipeline has settled
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_max(logic [23:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_BYTES;
        pwdata  <= {8'h00, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.limit_bytes = v;
        limits_used++;
    endtask

    // Mostly well-formed declaration with random content and faults
    task automatic make_decl();
        int          n;
        int          n_tok;
        int          k;
        int          cut;
        logic [23:0] lim;
        lim = board.limit_bytes;
        n   = $urandom_range(1, 8);
        repeat ($urandom_range(0, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 9))
            0: add_str("const unsigned ch");
            1: add_str("const unsigned ");
            default: begin
            end
        endcase
        add_str("const unsigned char arr");
        if ($urandom_range(0, 29) != 0) add_str("[");
        case ($urandom_range(0, 19))
            0: add_str(" ");
            1: add_str($sformatf("-%0d", n));
            2: add_str($sformatf(" \t+%0d", n));
            3: add_str("99999999999");
            4: begin
                n = lim;
                add_str($sformatf("%0d", lim));
            end
            5: add_str($sformatf("%0d", int'(lim) + 1));
            6: add_str($sformatf("%0du", n));
            7: add_str("0x10");
            default: add_str($sformatf("%s%0d", ($urandom_range(0, 3) == 0) ? "\n " : "", n));
        endcase
        if ($urandom_range(0, 29) != 0) add_str("] = ");
        else add_str(" = ");
        if ($urandom_range(0, 19) != 0) add_str("{");
        n_tok = (n > 10) ? 10 : n;
        k = ($urandom_range(0, 9) < 7) ? n_tok + $urandom_range(0, 2)
                                       : $urandom_range(0, n_tok - 1);
        for (int t = 0; t < k; t++) begin
            if (t != 0) add_str(($urandom_range(0, 3) == 0) ? ",\n    " : ", ");
            case ($urandom_range(0, 19))
                0: add_str("0xg");
                1: begin
                    add_str("0x");
                    text_buf.push_back(hex_char());
                    add_str("_");
                end
                2: add_str("0x0x");
                3: text_buf.push_back(8'($urandom_range(0, 255)));
                4: begin
                    add_str("00x");
                    text_buf.push_back(hex_char());
                    text_buf.push_back(hex_char());
                end
                default: begin
                    add_str($urandom_range(0, 1) ? "0x" : "0X");
                    text_buf.push_back(hex_char());
                    text_buf.push_back(hex_char());
                end
            endcase
        end
        add_str("\n};\n");
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, text_buf.size());
            while (text_buf.size() > cut) void'(text_buf.pop_back());
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned seg_start;
        logic [23:0] lim;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: character extremes and every closing status
        text_buf.push_back(8'h00);
        text_buf.push_back(8'hFF);
        send_text();
        add_str("const unsigned char a");
        send_text();
        add_str("const unsigned const unsigned char b[2]");
        send_text();
        add_str("const unsigned char c[ +3]={}");
        send_text();
        add_str("const unsigned char d[-1]={0x11}");
        send_text();
        add_str("const unsigned char f[3]={0x0g,0xA.,00x12,0x0x1,0x34,0x56};");
        send_text();
        add_str("const unsigned char g[9]={0x01,0XfE,0x7c");
        send_text();
        add_str("const unsigned char h[2]={0xAB,0xcD");
        send_text();
        drain();

        // Random texts: four flow-control modes, two limits each
        for (int mode = 0; mode < 4; mode++) begin
            gap_pct   = (mode == 1) ? 45 : (mode == 3) ? 22 : 0;
            stall_pct = (mode == 2) ? 45 : (mode == 3) ? 22 : 0;
            for (int s = 0; s < 2; s++) begin
                case (mode * 2 + s)
                    1: lim = 24'd1;
                    2: lim = 24'hFFFFFF;
                    3: lim = 24'd5;
                    4: lim = 24'($urandom_range(1, 12));
                    5: lim = 24'd3;
                    6: lim = 24'($urandom_range(1, 24'hFFFFFF));
                    7: lim = 24'd8;
                    default: lim = MAX_BYTES_RST;
                endcase
                if (mode * 2 + s != 0) write_max(lim);
                seg_start = chars_sent;
                while (chars_sent - seg_start < SEG_CHARS) begin
                    if ($urandom_range(0, 9) == 0) begin
                        repeat ($urandom_range(1, 12))
                            text_buf.push_back(8'($urandom_range(0, 255)));
                    end else begin
                        make_decl();
                    end
                    send_text();
                end
                drain();
            end
        end

        $display("Ran %0d texts (%0d characters) under %0d size limits and 4 flow modes",
                 texts_sent, chars_sent, limits_used);
        $display("Checked %0d result words, %0d bytes; final statuses seen %b",
                 board.words_checked, board.bytes_checked, board.status_seen[6:0]);
        if (board.errors == 0 && board.words_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/chx_pkg.sv
rtl/core/c_hex_array_text_to_bytes_unit.sv
rtl/core/chx_checker.sv
sim/tb.sv
